// File: sv/hmmtr_pkg.sv
package hmmtr_pkg;

  localparam int Q15_W   = 16;
  localparam int SEQ_W   = 40;
  localparam int MUL_W   = 56;
  localparam int SCALE_W = 57;

  localparam logic [Q15_W-1:0] ONE_Q15 = 16'h8000;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_XSI    = 3'd1,
    CMD_GAMMA  = 3'd2,
    CMD_ENDSEQ = 3'd3,
    CMD_UPDATE = 3'd4,
    CMD_READ   = 3'd5,
    CMD_NORM   = 3'd6
  } cmd_e;

endpackage

// File: sv/hmm_transition_reestimation.sv
// channel  | direction | handshake              | payload
// command  | in        | start && !busy         | cmd_i row_i col_i value_i weight_i
// result   | out       | done_o (one cycle)     | read_value_o div_zero_o
// config   | in        | cfg_we_i               | cfg_wdata_i (zero_threshold)
//
// load, add gamma, unused and out-of-range commands answer in the cycle after the
// request; in-range add xsi and read first pass through ST_DIR (one table read).
// end sequence steps through every entry on the shared 40x16 multiplier, which is
// used twice per scaled sum.
// update waits on the serial divider for each divided entry; normalize first sums
// each row, then divides each entry of that row by its sum on the serial divider.
// after reset a clearing pass over all NUM_STATES*NUM_STATES entries holds busy high.
// results cannot be stalled by the receiver.
module hmm_transition_reestimation #(
  parameter int NUM_STATES = 8,
  parameter int ACC_WIDTH  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd_i,
  input  logic [2:0]  row_i,
  input  logic [2:0]  col_i,
  input  logic [15:0] value_i,
  input  logic [31:0] weight_i,
  output logic        done_o,
  output logic [15:0] read_value_o,
  output logic        div_zero_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int NENT  = NUM_STATES * NUM_STATES;
  localparam int ENT_W = $clog2(NENT);
  localparam int ROW_W = $clog2(NUM_STATES);
  localparam int SUM_W = hmmtr_pkg::Q15_W + ROW_W;
  localparam int SW    = hmmtr_pkg::SEQ_W;
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIR,
    ST_E_D1, ST_E_D2, ST_E_RD, ST_E_M1, ST_E_M2,
    ST_U_RD, ST_U_EV, ST_U_DIV,
    ST_N_SRD, ST_N_SACC, ST_N_RD, ST_N_EV, ST_N_DIV
  } state_e;

  function automatic logic [ACC_WIDTH-1:0] acc_add(input logic [ACC_WIDTH-1:0] a,
                                                   input logic [hmmtr_pkg::SCALE_W-1:0] b);
    logic [64:0] s;
    s = 65'(a) + 65'(b);
    return (s > 65'(ACC_MAX)) ? ACC_MAX : s[ACC_WIDTH-1:0];
  endfunction

  function automatic logic [SW-1:0] seq_add(input logic [SW-1:0] a, input logic [15:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + (SW+1)'(b);
    return s[SW] ? {SW{1'b1}} : s[SW-1:0];
  endfunction

  state_e            state_q;
  hmmtr_pkg::cmd_e   cmd_q;
  logic [15:0]       thr_q;
  logic [15:0]       val_q;
  logic [31:0]       w_q;
  logic [ENT_W-1:0]  k_q;
  logic [ENT_W-1:0]  row_base_q;
  logic [ROW_W-1:0]  i_q;
  logic [ROW_W-1:0]  j_q;
  logic [SUM_W-1:0]  sum_q;
  logic [hmmtr_pkg::MUL_W-1:0]   p_q;
  logic [hmmtr_pkg::SCALE_W-1:0] sd_q;
  logic              dz_q;
  logic              done_q;
  logic [15:0]       rv_q;
  logic              dzo_q;
  logic [SW-1:0]     seq_den_q [NUM_STATES];

  logic              inr;
  logic [ENT_W-1:0]  idx;
  logic [ENT_W-1:0]  rd_addr;
  logic              k_last;
  logic              j_last;
  logic              dz_hit;

  logic [SW-1:0]     mul_a;
  logic [15:0]       mul_b;
  logic [hmmtr_pkg::MUL_W-1:0]   mul_p;
  logic [hmmtr_pkg::SCALE_W-1:0] scale_sum;

  logic                 tr_we, sn_we, tn_we, td_we;
  logic [ENT_W-1:0]     tr_waddr;
  logic [15:0]          tr_wdata, tr_rd;
  logic [SW-1:0]        sn_wdata, sn_rd;
  logic [ACC_WIDTH-1:0] tn_wdata, tn_rd, td_wdata, td_rd;

  logic                 div_start;
  logic                 div_done;
  logic [ACC_WIDTH-1:0] div_num, div_den;
  logic [15:0]          div_q;

  assign inr    = (32'(row_i) < NUM_STATES) && (32'(col_i) < NUM_STATES);
  assign idx    = ENT_W'(int'(row_i) * NUM_STATES + int'(col_i));
  assign k_last = (k_q == ENT_W'(NENT - 1));
  assign j_last = (j_q == ROW_W'(NUM_STATES - 1));
  assign busy   = (state_q != ST_IDLE);

  // the table read for add xsi and read starts with the request
  assign rd_addr = (state_q == ST_IDLE) ? idx : k_q;

  assign mul_p     = hmmtr_pkg::MUL_W'(mul_a) * hmmtr_pkg::MUL_W'(mul_b);
  assign scale_sum = hmmtr_pkg::SCALE_W'(mul_p) + hmmtr_pkg::SCALE_W'(p_q >> 16);

  always_comb begin
    tr_we    = 1'b0;
    sn_we    = 1'b0;
    tn_we    = 1'b0;
    td_we    = 1'b0;
    tr_waddr = k_q;
    tr_wdata = '0;
    sn_wdata = '0;
    tn_wdata = '0;
    td_wdata = '0;
    mul_a    = seq_den_q[i_q];
    mul_b    = w_q[15:0];
    div_start = 1'b0;
    div_num  = tn_rd;
    div_den  = td_rd;
    dz_hit   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        tr_we = 1'b1;
        sn_we = 1'b1;
        tn_we = 1'b1;
        td_we = 1'b1;
      end
      ST_IDLE: begin
        if (start && inr && (cmd_i == hmmtr_pkg::CMD_LOAD)) begin
          tr_we    = 1'b1;
          tr_waddr = idx;
          tr_wdata = (value_i > hmmtr_pkg::ONE_Q15) ? hmmtr_pkg::ONE_Q15 : value_i;
        end
      end
      ST_DIR: begin
        if ((cmd_q == hmmtr_pkg::CMD_XSI) && (tr_rd > thr_q)) begin
          sn_we    = 1'b1;
          sn_wdata = seq_add(sn_rd, val_q);
        end
      end
      ST_E_D2: mul_b = w_q[31:16];
      ST_E_M1: mul_a = sn_rd;
      ST_E_M2: begin
        mul_a    = sn_rd;
        mul_b    = w_q[31:16];
        sn_we    = 1'b1;
        tn_we    = 1'b1;
        td_we    = 1'b1;
        tn_wdata = acc_add(tn_rd, scale_sum);
        td_wdata = acc_add(td_rd, sd_q);
      end
      ST_U_EV: begin
        if (tr_rd <= thr_q) begin
          tr_we = 1'b1;
        end else if (td_rd == '0) begin
          tr_we    = 1'b1;
          tr_wdata = hmmtr_pkg::ONE_Q15;
          tn_we    = 1'b1;
          td_we    = 1'b1;
          dz_hit   = 1'b1;
        end else begin
          div_start = 1'b1;
        end
      end
      ST_U_DIV: begin
        if (div_done) begin
          tr_we    = 1'b1;
          tr_wdata = div_q;
          tn_we    = 1'b1;
          td_we    = 1'b1;
        end
      end
      ST_N_EV: begin
        div_num = ACC_WIDTH'(tr_rd);
        div_den = ACC_WIDTH'(sum_q);
        if (sum_q == '0) begin
          tr_we    = 1'b1;
          tr_wdata = hmmtr_pkg::ONE_Q15;
          dz_hit   = 1'b1;
        end else begin
          div_start = 1'b1;
        end
      end
      ST_N_DIV: begin
        if (div_done) begin
          tr_we    = 1'b1;
          tr_wdata = div_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cmd_q      <= hmmtr_pkg::CMD_LOAD;
      thr_q      <= '0;
      val_q      <= '0;
      w_q        <= '0;
      k_q        <= '0;
      row_base_q <= '0;
      i_q        <= '0;
      j_q        <= '0;
      sum_q      <= '0;
      p_q        <= '0;
      sd_q       <= '0;
      dz_q       <= 1'b0;
      done_q     <= 1'b0;
      rv_q       <= '0;
      dzo_q      <= 1'b0;
      for (int n = 0; n < NUM_STATES; n++) begin
        seq_den_q[n] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      done_q <= 1'b0;
      dz_q   <= dz_q | dz_hit;
      case (state_q)
        ST_CLEAR: begin
          k_q <= k_q + ENT_W'(1);
          if (k_last) begin
            k_q     <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            cmd_q <= hmmtr_pkg::cmd_e'(cmd_i);
            val_q <= value_i;
            w_q   <= weight_i;
            dz_q  <= 1'b0;
            rv_q  <= '0;
            dzo_q <= 1'b0;
            k_q   <= '0;
            i_q   <= '0;
            j_q   <= '0;
            sum_q <= '0;
            row_base_q <= '0;
            case (hmmtr_pkg::cmd_e'(cmd_i))
              hmmtr_pkg::CMD_GAMMA: begin
                if (inr) begin
                  seq_den_q[ROW_W'(row_i)] <= seq_add(seq_den_q[ROW_W'(row_i)], value_i);
                end
                done_q <= 1'b1;
              end
              hmmtr_pkg::CMD_XSI, hmmtr_pkg::CMD_READ: begin
                if (inr) begin
                  k_q     <= idx;
                  state_q <= ST_DIR;
                end else begin
                  done_q <= 1'b1;
                end
              end
              hmmtr_pkg::CMD_ENDSEQ: state_q <= ST_E_D1;
              hmmtr_pkg::CMD_UPDATE: state_q <= ST_U_RD;
              hmmtr_pkg::CMD_NORM:   state_q <= ST_N_SRD;
              default: done_q <= 1'b1;
            endcase
          end
        end
        ST_DIR: begin
          done_q  <= 1'b1;
          rv_q    <= (cmd_q == hmmtr_pkg::CMD_READ) ? tr_rd : '0;
          state_q <= ST_IDLE;
        end
        ST_E_D1: begin
          p_q     <= mul_p;
          state_q <= ST_E_D2;
        end
        ST_E_D2: begin
          sd_q    <= scale_sum;
          state_q <= ST_E_RD;
        end
        ST_E_RD: state_q <= ST_E_M1;
        ST_E_M1: begin
          p_q     <= mul_p;
          state_q <= ST_E_M2;
        end
        ST_E_M2: begin
          k_q <= k_q + ENT_W'(1);
          j_q <= j_q + ROW_W'(1);
          state_q <= ST_E_RD;
          if (j_last) begin
            seq_den_q[i_q] <= '0;
            j_q <= '0;
            i_q <= i_q + ROW_W'(1);
            state_q <= ST_E_D1;
            if (k_last) begin
              k_q     <= '0;
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
          end
        end
        ST_U_RD: state_q <= ST_U_EV;
        ST_U_EV, ST_U_DIV: begin
          if ((state_q == ST_U_DIV) ? div_done : !div_start) begin
            k_q     <= k_q + ENT_W'(1);
            state_q <= ST_U_RD;
            if (k_last) begin
              k_q     <= '0;
              done_q  <= 1'b1;
              dzo_q   <= dz_q | dz_hit;
              state_q <= ST_IDLE;
            end
          end else if (state_q == ST_U_EV) begin
            state_q <= ST_U_DIV;
          end
        end
        ST_N_SRD: state_q <= ST_N_SACC;
        ST_N_SACC: begin
          sum_q <= sum_q + SUM_W'(tr_rd);
          if (j_last) begin
            j_q     <= '0;
            k_q     <= row_base_q;
            state_q <= ST_N_RD;
          end else begin
            j_q     <= j_q + ROW_W'(1);
            k_q     <= k_q + ENT_W'(1);
            state_q <= ST_N_SRD;
          end
        end
        ST_N_RD: state_q <= ST_N_EV;
        ST_N_EV, ST_N_DIV: begin
          if ((state_q == ST_N_DIV) ? div_done : !div_start) begin
            k_q     <= k_q + ENT_W'(1);
            j_q     <= j_q + ROW_W'(1);
            state_q <= ST_N_RD;
            if (j_last) begin
              j_q        <= '0;
              sum_q      <= '0;
              row_base_q <= k_q + ENT_W'(1);
              state_q    <= ST_N_SRD;
              if (k_last) begin
                k_q     <= '0;
                done_q  <= 1'b1;
                dzo_q   <= dz_q | dz_hit;
                state_q <= ST_IDLE;
              end
            end
          end else if (state_q == ST_N_EV) begin
            state_q <= ST_N_DIV;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  hmmtr_ram #(.WIDTH(16), .DEPTH(NENT)) u_trans (
    .clk_i, .we_i(tr_we), .waddr_i(tr_waddr), .wdata_i(tr_wdata),
    .raddr_i(rd_addr), .rdata_o(tr_rd)
  );

  hmmtr_ram #(.WIDTH(SW), .DEPTH(NENT)) u_seq_numer (
    .clk_i, .we_i(sn_we), .waddr_i(k_q), .wdata_i(sn_wdata),
    .raddr_i(rd_addr), .rdata_o(sn_rd)
  );

  hmmtr_ram #(.WIDTH(ACC_WIDTH), .DEPTH(NENT)) u_total_numer (
    .clk_i, .we_i(tn_we), .waddr_i(k_q), .wdata_i(tn_wdata),
    .raddr_i(k_q), .rdata_o(tn_rd)
  );

  hmmtr_ram #(.WIDTH(ACC_WIDTH), .DEPTH(NENT)) u_total_denom (
    .clk_i, .we_i(td_we), .waddr_i(k_q), .wdata_i(td_wdata),
    .raddr_i(k_q), .rdata_o(td_rd)
  );

  hmmtr_div #(.W(ACC_WIDTH)) u_div (
    .clk_i,
    .rst_ni,
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_q)
  );

  assign done_o       = done_q;
  assign read_value_o = rv_q;
  assign div_zero_o   = dzo_q;

  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i == hmmtr_pkg::CMD_LOAD)) |=> (done_o && !busy))
    else $error("load did not answer in one cycle");

  a_dz_from_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && div_zero_o) |->
      ((cmd_q == hmmtr_pkg::CMD_UPDATE) || (cmd_q == hmmtr_pkg::CMD_NORM)))
    else $error("div_zero on a command that never divides");

  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (read_value_o <= hmmtr_pkg::ONE_Q15))
    else $error("read value above one");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((state_q == ST_U_DIV) || (state_q == ST_N_DIV)))
    else $error("divider finished while not awaited");

endmodule

// File: sv/hmmtr_ram.sv
module hmmtr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/hmmtr_div.sv
module hmmtr_div #(
  parameter int W = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [W-1:0]                num_i,
  input  logic [W-1:0]                den_i,
  output logic                        done_o,
  output logic [hmmtr_pkg::Q15_W-1:0] quot_o
);

  typedef enum logic {
    D_IDLE,
    D_RUN
  } dstate_e;

  dstate_e                      state_q;
  logic [W-1:0]                 rem_q;
  logic [W-1:0]                 den_q;
  logic [hmmtr_pkg::Q15_W-1:0]  quot_q;
  logic [3:0]                   cnt_q;
  logic                         done_q;
  logic [W:0]                   rem2;
  logic [W:0]                   diff;
  logic                         ge;

  // one restoring step per cycle
  assign rem2 = {rem_q, 1'b0};
  assign diff = rem2 - {1'b0, den_q};
  assign ge   = (rem2 >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      rem_q   <= '0;
      den_q   <= '0;
      quot_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            den_q <= den_i;
            if (num_i >= den_i) begin
              quot_q <= hmmtr_pkg::ONE_Q15;
              done_q <= 1'b1;
            end else begin
              rem_q   <= num_i;
              quot_q  <= '0;
              cnt_q   <= '0;
              state_q <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem_q  <= ge ? diff[W-1:0] : rem2[W-1:0];
          quot_q <= {quot_q[hmmtr_pkg::Q15_W-2:0], ge};
          cnt_q  <= cnt_q + 4'd1;
          if (cnt_q == 4'd14) begin
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
